// ===== design/rhc_pkg.sv =====
// Shared constants and types for the reference-counted handle cache.
`timescale 1ns / 1ps

package rhc_pkg;

    // Table geometry.
    localparam int ENTRIES  = 16;
    localparam int REF_BITS = 16;
    localparam int IDX_W    = $clog2(ENTRIES);

    // Field widths of the request and response beats.
    localparam int OP_W       = 2;
    localparam int COLL_W     = 32;
    localparam int KEY_W      = 64;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int REFS_OUT_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_GET    = 2'd0,
        OP_PUT    = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_BUSY      = 3'd2,
        ST_NO_MATCH  = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

endpackage

// ===== design/rhc_if.sv =====
// Request and response channel interfaces of the handle cache.
`timescale 1ns / 1ps

interface rhc_req_if;
    logic                        valid;
    logic                        ready;
    logic [rhc_pkg::OP_W-1:0]    operation;
    logic [rhc_pkg::COLL_W-1:0]  collection;
    logic [rhc_pkg::KEY_W-1:0]   object_key;
    logic                        create;
    logic                        exists;

    modport source (output valid, operation, collection, object_key, create, exists,
                    input ready);
    modport sink   (input valid, operation, collection, object_key, create, exists,
                    output ready);
endinterface

interface rhc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [rhc_pkg::STATUS_W-1:0]    status;
    logic [rhc_pkg::SLOT_OUT_W-1:0]  slot;
    logic                            hit;
    logic                            evicted;
    logic [rhc_pkg::REFS_OUT_W-1:0]  references;

    modport source (output valid, status, slot, hit, evicted, references,
                    input ready);
    modport sink   (input valid, status, slot, hit, evicted, references,
                    output ready);
endinterface

// ===== design/refcounted_handle_cache.sv =====
// Top level of the reference-counted handle cache: table, scan sequencer and result register.
`timescale 1ns / 1ps

// The cache holds ENTRIES open objects, each keyed by a collection id and a 64-bit handle,
// with a valid bit and a saturating reference count. A request beat is taken only while
// the block is idle; a single 96-bit key comparator then walks the table one slot per
// cycle, noting the first matching slot, the first free slot and the first valid slot
// with no references. The update state then applies the get, put or remove to the chosen
// slot and loads the response register. The next request is taken in the cycle after the
// response beat leaves. Among candidates of one kind the lowest slot index wins. The valid
// bits are cleared by reset; keys and counts are only looked at in valid slots, so they
// need no clearing.
module refcounted_handle_cache (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rhc_req_if.sink    i_req,
    rhc_rsp_if.source  o_rsp
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Table storage.
    logic [rhc_pkg::ENTRIES-1:0]  r_valid;
    logic [rhc_pkg::COLL_W-1:0]   r_coll_tab [rhc_pkg::ENTRIES];
    logic [rhc_pkg::KEY_W-1:0]    r_key_tab  [rhc_pkg::ENTRIES];
    logic [rhc_pkg::REF_BITS-1:0] r_refs_tab [rhc_pkg::ENTRIES];

    // Captured request.
    logic [rhc_pkg::OP_W-1:0]   r_op;
    logic [rhc_pkg::COLL_W-1:0] r_coll;
    logic [rhc_pkg::KEY_W-1:0]  r_key;
    logic                       r_create;
    logic                       r_exists;

    // Scan position and what the walk has found so far.
    logic [rhc_pkg::IDX_W-1:0]    r_idx;
    logic                         r_found;
    logic [rhc_pkg::IDX_W-1:0]    r_match_idx;
    logic [rhc_pkg::REF_BITS-1:0] r_match_refs;
    logic                         r_free_ok;
    logic [rhc_pkg::IDX_W-1:0]    r_free_idx;
    logic                         r_zero_ok;
    logic [rhc_pkg::IDX_W-1:0]    r_zero_idx;

    // Response register.
    logic [rhc_pkg::STATUS_W-1:0]   r_status;
    logic [rhc_pkg::SLOT_OUT_W-1:0] r_slot;
    logic                           r_hit;
    logic                           r_evicted;
    logic [rhc_pkg::REFS_OUT_W-1:0] r_refs_out;

    logic req_take;
    logic rsp_take;
    logic scan_last;
    logic scan_valid;
    logic scan_match;
    logic scan_zero;

    // Update decision.
    logic [rhc_pkg::STATUS_W-1:0] n_status;
    logic [rhc_pkg::IDX_W-1:0]    n_slot_idx;
    logic                         n_hit;
    logic                         n_evicted;
    logic [rhc_pkg::REF_BITS-1:0] n_refs;
    logic                         wr_refs_en;
    logic                         wr_valid_en;
    logic                         wr_valid_val;
    logic                         wr_key_en;
    logic [rhc_pkg::IDX_W-1:0]    wr_idx;
    logic                         pick_ok;
    logic [rhc_pkg::IDX_W-1:0]    pick_idx;
    logic                         refs_full;

    assign req_take  = i_req.valid && i_req.ready;
    assign rsp_take  = o_rsp.valid && o_rsp.ready;
    assign scan_last = (r_idx == rhc_pkg::IDX_W'(rhc_pkg::ENTRIES - 1));

    // The shared comparator: one slot per cycle against the captured key.
    assign scan_valid = r_valid[r_idx];
    assign scan_match = scan_valid && (r_coll_tab[r_idx] == r_coll)
                        && (r_key_tab[r_idx] == r_key);
    assign scan_zero  = scan_valid && (r_refs_tab[r_idx] == '0);

    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid      = (r_state == S_DONE);
    assign o_rsp.status     = r_status;
    assign o_rsp.slot       = r_slot;
    assign o_rsp.hit        = r_hit;
    assign o_rsp.evicted    = r_evicted;
    assign o_rsp.references = r_refs_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (req_take) n_state = S_SCAN;
            S_SCAN:   if (scan_last) n_state = S_UPDATE;
            S_UPDATE: n_state = S_DONE;
            S_DONE:   if (rsp_take) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // On a get miss an invalid slot is preferred over evicting an unreferenced one.
    assign pick_ok   = r_free_ok || r_zero_ok;
    assign pick_idx  = r_free_ok ? r_free_idx : r_zero_idx;
    assign refs_full = (r_match_refs == '1);

    always_comb begin
        n_status     = rhc_pkg::ST_NO_MATCH;
        n_slot_idx   = '0;
        n_hit        = 1'b0;
        n_evicted    = 1'b0;
        n_refs       = '0;
        wr_refs_en   = 1'b0;
        wr_valid_en  = 1'b0;
        wr_valid_val = 1'b0;
        wr_key_en    = 1'b0;
        wr_idx       = r_match_idx;
        case (r_op)
            rhc_pkg::OP_GET: begin
                if (r_found) begin
                    n_slot_idx = r_match_idx;
                    n_hit      = 1'b1;
                    if (refs_full) begin
                        // Count is saturated: report busy and leave it.
                        n_status = rhc_pkg::ST_BUSY;
                        n_refs   = r_match_refs;
                    end else begin
                        n_status   = rhc_pkg::ST_OK;
                        n_refs     = r_match_refs + 1'b1;
                        wr_refs_en = 1'b1;
                    end
                end else if (!pick_ok) begin
                    n_status = rhc_pkg::ST_FULL;
                end else begin
                    n_slot_idx  = pick_idx;
                    n_evicted   = !r_free_ok;
                    wr_idx      = pick_idx;
                    wr_valid_en = 1'b1;
                    wr_refs_en  = 1'b1;
                    if (r_exists || r_create) begin
                        n_status     = rhc_pkg::ST_OK;
                        n_refs       = rhc_pkg::REF_BITS'(1);
                        wr_valid_val = 1'b1;
                        wr_key_en    = 1'b1;
                    end else begin
                        // The chosen slot is still vacated, even when nothing is installed.
                        n_status = rhc_pkg::ST_NOT_FOUND;
                    end
                end
            end
            rhc_pkg::OP_PUT: begin
                if (r_found) begin
                    n_status   = rhc_pkg::ST_OK;
                    n_slot_idx = r_match_idx;
                    n_hit      = 1'b1;
                    n_refs     = (r_match_refs == '0) ? '0 : r_match_refs - 1'b1;
                    wr_refs_en = 1'b1;
                end
            end
            rhc_pkg::OP_REMOVE: begin
                if (r_found && (r_match_refs != '0)) begin
                    n_status   = rhc_pkg::ST_BUSY;
                    n_slot_idx = r_match_idx;
                    n_hit      = 1'b1;
                    n_refs     = r_match_refs;
                end else begin
                    n_status    = r_exists ? rhc_pkg::ST_OK : rhc_pkg::ST_NOT_FOUND;
                    n_slot_idx  = r_found ? r_match_idx : '0;
                    n_hit       = r_found;
                    wr_valid_en = r_found;
                    wr_refs_en  = r_found;
                end
            end
            default: begin
                n_status = rhc_pkg::ST_NO_MATCH;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_UPDATE) && wr_valid_en) begin
                r_valid[wr_idx] <= wr_valid_val;
            end
        end
    end

    // Datapath registers; none of these is read before the sequencer has loaded it.
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_op         <= i_req.operation;
            r_coll       <= i_req.collection;
            r_key        <= i_req.object_key;
            r_create     <= i_req.create;
            r_exists     <= i_req.exists;
            r_idx        <= '0;
            r_found      <= 1'b0;
            r_free_ok    <= 1'b0;
            r_zero_ok    <= 1'b0;
            r_match_idx  <= '0;
            r_match_refs <= '0;
            r_free_idx   <= '0;
            r_zero_idx   <= '0;
        end
        if (r_state == S_SCAN) begin
            r_idx <= r_idx + 1'b1;
            if (scan_match && !r_found) begin
                r_found      <= 1'b1;
                r_match_idx  <= r_idx;
                r_match_refs <= r_refs_tab[r_idx];
            end
            if (!scan_valid && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_idx;
            end
            if (scan_zero && !r_zero_ok) begin
                r_zero_ok  <= 1'b1;
                r_zero_idx <= r_idx;
            end
        end
        if (r_state == S_UPDATE) begin
            if (wr_refs_en) begin
                r_refs_tab[wr_idx] <= n_refs;
            end
            if (wr_key_en) begin
                r_coll_tab[wr_idx] <= r_coll;
                r_key_tab[wr_idx]  <= r_key;
            end
            r_status   <= n_status;
            r_slot     <= rhc_pkg::SLOT_OUT_W'(n_slot_idx);
            r_hit      <= n_hit;
            r_evicted  <= n_evicted;
            r_refs_out <= rhc_pkg::REFS_OUT_W'(n_refs);
        end
    end

endmodule

// ===== design/rhc_checker.sv =====
// Port-level assertions for the handle cache and the bind that attaches them.
`timescale 1ns / 1ps

module rhc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_req_valid,
    input logic                             i_req_ready,
    input logic                             i_rsp_valid,
    input logic                             i_rsp_ready,
    input logic [rhc_pkg::STATUS_W-1:0]     i_status,
    input logic [rhc_pkg::SLOT_OUT_W-1:0]   i_slot,
    input logic                             i_hit,
    input logic                             i_evicted,
    input logic [rhc_pkg::REFS_OUT_W-1:0]   i_references
);

    // A pending response beat stays until it is taken.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("response beat dropped before it was taken");

    // Once a request is taken, no other is taken until its work is done.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while the previous one is in flight");

    // The table serves one request at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !i_req_ready)
        else $error("request port open while a response is pending");

    // A miss on put or an unknown operation names no slot and no count.
    a_no_match_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_status == rhc_pkg::ST_NO_MATCH)) |->
        (i_slot == '0 && !i_hit && !i_evicted && i_references == '0))
        else $error("no-match response carries slot data");

    // Only a get miss can evict, and it always reports one reference or none.
    a_evict_install: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_evicted) |->
        (!i_hit && (i_status == rhc_pkg::ST_OK || i_status == rhc_pkg::ST_NOT_FOUND)
         && i_references <= rhc_pkg::REFS_OUT_W'(1)))
        else $error("eviction reported outside a get miss");

endmodule

bind refcounted_handle_cache rhc_checker u_rhc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_slot       (o_rsp.slot),
    .i_hit        (o_rsp.hit),
    .i_evicted    (o_rsp.evicted),
    .i_references (o_rsp.references)
);

// ===== verif/handle_cache_checker.sv =====
// Checker for the handle cache: mirrors the table, predicts each response beat and compares.
`timescale 1ns / 1ps

module handle_cache_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    input  logic                           i_req_ready,
    input  logic [rhc_pkg::OP_W-1:0]       i_req_operation,
    input  logic [rhc_pkg::COLL_W-1:0]     i_req_collection,
    input  logic [rhc_pkg::KEY_W-1:0]      i_req_object_key,
    input  logic                           i_req_create,
    input  logic                           i_req_exists,
    input  logic                           i_rsp_valid,
    input  logic                           i_rsp_ready,
    input  logic [rhc_pkg::STATUS_W-1:0]   i_rsp_status,
    input  logic [rhc_pkg::SLOT_OUT_W-1:0] i_rsp_slot,
    input  logic                           i_rsp_hit,
    input  logic                           i_rsp_evicted,
    input  logic [rhc_pkg::REFS_OUT_W-1:0] i_rsp_references,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_evictions,
    output int                             o_full_seen,
    output int                             o_busy_seen
);

    typedef struct packed {
        logic [rhc_pkg::STATUS_W-1:0]   status;
        logic [rhc_pkg::SLOT_OUT_W-1:0] slot;
        logic                           hit;
        logic                           evicted;
        logic [rhc_pkg::REFS_OUT_W-1:0] references;
    } t_cache_rsp;

    // Mirror of the table. Keys are only compared where the valid bit is set.
    logic                         tbl_valid [rhc_pkg::ENTRIES];
    logic [rhc_pkg::COLL_W-1:0]   tbl_coll  [rhc_pkg::ENTRIES];
    logic [rhc_pkg::KEY_W-1:0]    tbl_key   [rhc_pkg::ENTRIES];
    logic [rhc_pkg::REF_BITS-1:0] tbl_refs  [rhc_pkg::ENTRIES];

    t_cache_rsp expected_rsp_q [$];
    int fail_count = 0;
    int checked = 0;
    int evictions = 0;
    int full_seen = 0;
    int busy_seen = 0;

    function automatic t_cache_rsp predict_cache_response(
        input logic [rhc_pkg::OP_W-1:0]   op,
        input logic [rhc_pkg::COLL_W-1:0] coll,
        input logic [rhc_pkg::KEY_W-1:0]  key,
        input logic                       create,
        input logic                       exists
    );
        t_cache_rsp rsp;
        int         hit_idx;
        int         pick;
        logic       ev;
        rsp = '0;
        hit_idx = -1;
        pick = -1;
        ev = 1'b0;
        for (int i = 0; i < rhc_pkg::ENTRIES; i++) begin
            if (hit_idx < 0 && tbl_valid[i] && tbl_coll[i] == coll && tbl_key[i] == key) begin
                hit_idx = i;
            end
        end
        case (op)
            rhc_pkg::OP_GET: begin
                if (hit_idx >= 0) begin
                    rsp.hit = 1'b1;
                    rsp.slot = hit_idx[rhc_pkg::SLOT_OUT_W-1:0];
                    if (tbl_refs[hit_idx] == '1) begin
                        rsp.status = rhc_pkg::ST_BUSY;
                    end else begin
                        tbl_refs[hit_idx] = tbl_refs[hit_idx] + 1'b1;
                        rsp.status = rhc_pkg::ST_OK;
                    end
                    rsp.references = tbl_refs[hit_idx];
                end else begin
                    // A free slot wins over an unreferenced one; lowest index first.
                    for (int i = 0; i < rhc_pkg::ENTRIES; i++) begin
                        if (pick < 0 && !tbl_valid[i]) begin
                            pick = i;
                        end
                    end
                    for (int i = 0; i < rhc_pkg::ENTRIES; i++) begin
                        if (pick < 0 && tbl_refs[i] == '0) begin
                            pick = i;
                            ev = 1'b1;
                        end
                    end
                    if (pick < 0) begin
                        rsp.status = rhc_pkg::ST_FULL;
                    end else begin
                        rsp.slot = pick[rhc_pkg::SLOT_OUT_W-1:0];
                        rsp.evicted = ev;
                        tbl_valid[pick] = 1'b0;
                        tbl_refs[pick] = '0;
                        if (!exists && !create) begin
                            rsp.status = rhc_pkg::ST_NOT_FOUND;
                        end else begin
                            tbl_valid[pick] = 1'b1;
                            tbl_coll[pick] = coll;
                            tbl_key[pick] = key;
                            tbl_refs[pick] = rhc_pkg::REF_BITS'(1);
                            rsp.status = rhc_pkg::ST_OK;
                            rsp.references = rhc_pkg::REFS_OUT_W'(1);
                        end
                    end
                end
            end
            rhc_pkg::OP_PUT: begin
                if (hit_idx < 0) begin
                    rsp.status = rhc_pkg::ST_NO_MATCH;
                end else begin
                    if (tbl_refs[hit_idx] != '0) begin
                        tbl_refs[hit_idx] = tbl_refs[hit_idx] - 1'b1;
                    end
                    rsp.status = rhc_pkg::ST_OK;
                    rsp.slot = hit_idx[rhc_pkg::SLOT_OUT_W-1:0];
                    rsp.hit = 1'b1;
                    rsp.references = tbl_refs[hit_idx];
                end
            end
            rhc_pkg::OP_REMOVE: begin
                if (hit_idx >= 0 && tbl_refs[hit_idx] != '0) begin
                    rsp.status = rhc_pkg::ST_BUSY;
                    rsp.slot = hit_idx[rhc_pkg::SLOT_OUT_W-1:0];
                    rsp.hit = 1'b1;
                    rsp.references = tbl_refs[hit_idx];
                end else begin
                    if (hit_idx >= 0) begin
                        tbl_valid[hit_idx] = 1'b0;
                        tbl_refs[hit_idx] = '0;
                        rsp.slot = hit_idx[rhc_pkg::SLOT_OUT_W-1:0];
                        rsp.hit = 1'b1;
                    end
                    rsp.status = exists ? rhc_pkg::ST_OK : rhc_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                rsp.status = rhc_pkg::ST_NO_MATCH;
            end
        endcase
        return rsp;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] MISMATCH %s", $realtime, msg);
        end
    endfunction

    always @(posedge i_clk) begin
        t_cache_rsp exp_rsp;
        t_cache_rsp got_rsp;
        if (!i_rst_n) begin
            for (int i = 0; i < rhc_pkg::ENTRIES; i++) begin
                tbl_valid[i] = 1'b0;
                tbl_coll[i] = '0;
                tbl_key[i] = '0;
                tbl_refs[i] = '0;
            end
            expected_rsp_q.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                expected_rsp_q.push_back(predict_cache_response(i_req_operation,
                    i_req_collection, i_req_object_key, i_req_create, i_req_exists));
            end
            if (i_rsp_valid && i_rsp_ready) begin
                got_rsp = '{i_rsp_status, i_rsp_slot, i_rsp_hit, i_rsp_evicted,
                            i_rsp_references};
                if (expected_rsp_q.size() == 0) begin
                    note_failure($sformatf("response beat with nothing outstanding: %p",
                                           got_rsp));
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    checked++;
                    if (exp_rsp.evicted) evictions++;
                    if (exp_rsp.status == rhc_pkg::ST_FULL) full_seen++;
                    if (exp_rsp.status == rhc_pkg::ST_BUSY) busy_seen++;
                    if (got_rsp.status !== exp_rsp.status || got_rsp.slot !== exp_rsp.slot ||
                        got_rsp.hit !== exp_rsp.hit || got_rsp.evicted !== exp_rsp.evicted ||
                        got_rsp.references !== exp_rsp.references) begin
                        note_failure($sformatf({"response %0d: expected status %0d slot %0d ",
                            "hit %0b evicted %0b refs %0d, got status %0d slot %0d hit %0b ",
                            "evicted %0b refs %0d"}, checked,
                            exp_rsp.status, exp_rsp.slot, exp_rsp.hit, exp_rsp.evicted,
                            exp_rsp.references, got_rsp.status, got_rsp.slot, got_rsp.hit,
                            got_rsp.evicted, got_rsp.references));
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending <= expected_rsp_q.size();
        o_checked <= checked;
        o_evictions <= evictions;
        o_full_seen <= full_seen;
        o_busy_seen <= busy_seen;
    end

endmodule

// ===== verif/refcounted_handle_cache_test.sv =====
// Testbench top for the handle cache: request and back-pressure stimulus, and the verdict.
`timescale 1ns / 1ps

module refcounted_handle_cache_test;

    // Operation code the block does not define; it must answer with no match.
    localparam logic [rhc_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

    localparam int KEY_POOL     = 20;
    localparam int RANDOM_ITEMS = 1450;
    localparam int CALM_TAIL    = 200;
    localparam int PHASE_LEN    = 60;

    logic clk;
    logic rst_n;
    bit   src_idle_on;
    bit   snk_idle_on;

    // A small key pool keeps the table busy with hits, evictions and full conditions.
    logic [rhc_pkg::COLL_W-1:0] pool_coll [KEY_POOL];
    logic [rhc_pkg::KEY_W-1:0]  pool_key  [KEY_POOL];

    int fail_count;
    int pending;
    int checked;
    int evictions;
    int full_seen;
    int busy_seen;

    rhc_req_if req_ch ();
    rhc_rsp_if rsp_ch ();

    refcounted_handle_cache dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    handle_cache_checker cache_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_req_valid      (req_ch.valid),
        .i_req_ready      (req_ch.ready),
        .i_req_operation  (req_ch.operation),
        .i_req_collection (req_ch.collection),
        .i_req_object_key (req_ch.object_key),
        .i_req_create     (req_ch.create),
        .i_req_exists     (req_ch.exists),
        .i_rsp_valid      (rsp_ch.valid),
        .i_rsp_ready      (rsp_ch.ready),
        .i_rsp_status     (rsp_ch.status),
        .i_rsp_slot       (rsp_ch.slot),
        .i_rsp_hit        (rsp_ch.hit),
        .i_rsp_evicted    (rsp_ch.evicted),
        .i_rsp_references (rsp_ch.references),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_evictions      (evictions),
        .o_full_seen      (full_seen),
        .o_busy_seen      (busy_seen)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Response back-pressure: stall bursts of random length while enabled.
    initial begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!rst_n) begin
                rsp_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (snk_idle_on && $urandom_range(0, 15) == 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 18) - 1;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Presents one request beat and returns at the edge that accepts it. Valid stays high
    // so that a back-to-back beat does not toggle it within one time step.
    task automatic send_request(input logic [rhc_pkg::OP_W-1:0] op,
                                input logic [rhc_pkg::COLL_W-1:0] coll,
                                input logic [rhc_pkg::KEY_W-1:0] key, input logic create,
                                input logic exists);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.collection <= coll;
        req_ch.object_key <= key;
        req_ch.create     <= create;
        req_ch.exists     <= exists;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
    endtask

    // Random request; a draining phase favors puts so that references fall again.
    task automatic send_random_request(input bit drain);
        int                         roll;
        int                         pick;
        logic [rhc_pkg::OP_W-1:0]   op;
        logic [rhc_pkg::COLL_W-1:0] coll;
        logic [rhc_pkg::KEY_W-1:0]  key;
        roll = $urandom_range(0, 99);
        if (roll == 0) begin
            op = OP_RESERVED;
        end else if (roll < (drain ? 25 : 60)) begin
            op = rhc_pkg::OP_GET;
        end else if (roll < (drain ? 75 : 85)) begin
            op = rhc_pkg::OP_PUT;
        end else begin
            op = rhc_pkg::OP_REMOVE;
        end
        if ($urandom_range(0, 9) == 0) begin
            coll = $urandom;
            key = {$urandom, $urandom};
        end else begin
            pick = $urandom_range(0, KEY_POOL - 1);
            coll = pool_coll[pick];
            key = pool_key[pick];
        end
        send_request(op, coll, key, $urandom_range(0, 3) == 0, $urandom_range(0, 4) != 0);
    endtask

    initial begin
        logic [rhc_pkg::COLL_W-1:0] sat_coll;
        logic [rhc_pkg::KEY_W-1:0]  sat_key;
        bit                         drain;
        bit                         calm;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.operation  <= rhc_pkg::OP_GET;
        req_ch.collection <= '0;
        req_ch.object_key <= '0;
        req_ch.create     <= 1'b0;
        req_ch.exists     <= 1'b0;
        src_idle_on = 1'b0;
        snk_idle_on <= 1'b0;
        drain = 1'b0;
        for (int i = 0; i < KEY_POOL; i++) begin
            pool_coll[i] = $urandom;
            pool_key[i] = {$urandom, $urandom};
        end
        // Extreme keys, and two keys that match the key at index 4 in one half only.
        pool_coll[0] = '0;
        pool_key[0] = '0;
        pool_coll[1] = '1;
        pool_key[1] = '1;
        pool_coll[2] = pool_coll[4];
        pool_key[3] = pool_key[4];
        sat_coll = $urandom;
        sat_key = {$urandom, $urandom};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A get of an absent object without create leaves the slot free; with create the
        // key goes in. A referenced entry refuses removal, and a put at zero stays at zero.
        send_request(rhc_pkg::OP_GET, pool_coll[4], pool_key[4], 1'b0, 1'b0);
        send_request(rhc_pkg::OP_GET, pool_coll[4], pool_key[4], 1'b1, 1'b0);
        send_request(rhc_pkg::OP_REMOVE, pool_coll[4], pool_key[4], 1'b0, 1'b1);
        send_request(rhc_pkg::OP_PUT, pool_coll[4], pool_key[4], 1'b0, 1'b1);
        send_request(rhc_pkg::OP_PUT, pool_coll[4], pool_key[4], 1'b0, 1'b1);

        // Install a second entry and move its count up and down; it refuses removal
        // while referenced. This entry stays pinned in slot 1 for the rest of the run.
        send_request(rhc_pkg::OP_GET, sat_coll, sat_key, 1'b0, 1'b1);
        send_request(rhc_pkg::OP_GET, sat_coll, sat_key, 1'b0, 1'b1);
        send_request(rhc_pkg::OP_PUT, sat_coll, sat_key, 1'b0, 1'b1);
        send_request(rhc_pkg::OP_GET, sat_coll, sat_key, 1'b1, 1'b0);
        send_request(rhc_pkg::OP_GET, sat_coll, sat_key, 1'b0, 1'b1);
        send_request(rhc_pkg::OP_REMOVE, sat_coll, sat_key, 1'b0, 1'b1);

        // Fill every other slot, including the extreme and half-matching keys.
        for (int i = 0; i < 16; i++) begin
            if (i != 4 && i != 5) begin
                send_request(rhc_pkg::OP_GET, pool_coll[i], pool_key[i], i[0], 1'b1);
            end
        end
        // Only slot 0 is unreferenced: it is evicted but, with no object, left free.
        send_request(rhc_pkg::OP_GET, $urandom, {$urandom, $urandom}, 1'b0, 1'b0);
        send_request(rhc_pkg::OP_GET, pool_coll[16], pool_key[16], 1'b0, 1'b1);
        send_request(rhc_pkg::OP_GET, pool_coll[17], pool_key[17], 1'b1, 1'b1);
        send_request(rhc_pkg::OP_PUT, pool_coll[16], pool_key[16], 1'b0, 1'b1);
        send_request(rhc_pkg::OP_REMOVE, pool_coll[16], pool_key[16], 1'b0, 1'b0);
        send_request(rhc_pkg::OP_REMOVE, pool_coll[17], pool_key[17], 1'b0, 1'b1);
        send_request(rhc_pkg::OP_PUT, pool_coll[17], pool_key[17], 1'b0, 1'b1);
        send_request(OP_RESERVED, pool_coll[0], pool_key[0], 1'b1, 1'b1);

        // Random phases alternate between filling and draining; the tail runs calm.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_LEN == 0 || n == RANDOM_ITEMS - CALM_TAIL) begin
                drain = (n / PHASE_LEN) % 2 == 1;
                calm = n >= RANDOM_ITEMS - CALM_TAIL;
                src_idle_on = !calm && $urandom_range(0, 3) != 0;
                snk_idle_on <= !calm && $urandom_range(0, 3) != 0;
            end
            send_random_request(drain);
        end
        req_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Checked %0d responses, including %0d random requests: %0d evictions,",
                 checked, RANDOM_ITEMS, evictions);
        $display("%0d table-full and %0d busy answers over fill, drain and calm phases.",
                 full_seen, busy_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("refcounted_handle_cache regression: pass");
        end else begin
            $display("refcounted_handle_cache regression: fail");
        end
        $finish;
    end

    // About 1500 requests finish well within this limit even with the longest stalls.
    initial begin
        #20_000_000;
        $display("refcounted_handle_cache regression: fail");
        $finish;
    end

endmodule
